### design/eosf_pkg.sv
// ----------------------------------------------------------------------------
// eosf_pkg
// Shared widths, the boundary reset value and register index, and the span
// record for the even-odd scanline span fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package eosf_pkg;

    // Widths of the pixel word and of the reported coordinates.
    localparam int PIX_W   = 32;
    localparam int COORD_W = 11;

    // Boundary color after reset.
    localparam logic [PIX_W-1:0] BOUNDARY_RESET = 32'hFF00_00FF;

    // Register index of the boundary color in the configuration space.
    localparam logic REG_BOUNDARY = 1'b0;

    // One span to fill: row, first and last column.
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] first;
        logic [COORD_W-1:0] last;
    } t_span;

endpackage

`default_nettype wire

### design/eosf_cfg.sv
// ----------------------------------------------------------------------------
// eosf_cfg
// APB-style register port holding the boundary color.
// ----------------------------------------------------------------------------
`default_nettype none

module eosf_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [eosf_pkg::PIX_W-1:0] pwdata,
    output logic      [eosf_pkg::PIX_W-1:0] prdata,
    output logic                            pready,
    output logic      [eosf_pkg::PIX_W-1:0] o_boundary
);

    logic [eosf_pkg::PIX_W-1:0] r_boundary;
    logic                       w_sel;

    // The register index is the word address above the byte offset.
    assign w_sel  = (paddr[2] == eosf_pkg::REG_BOUNDARY);
    assign pready = 1'b1;

    // The boundary color is written in the access phase of a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boundary <= eosf_pkg::BOUNDARY_RESET;
        end else if (psel && penable && pwrite && pready && w_sel) begin
            r_boundary <= pwdata;
        end
    end

    // Reads of addresses beyond the register return zero.
    assign prdata     = w_sel ? r_boundary : '0;
    assign o_boundary = r_boundary;

endmodule

`default_nettype wire

### design/eosf_scan.sv
// ----------------------------------------------------------------------------
// eosf_scan
// Scan state machine: tracks the opening boundary run, the transparent gap
// and the closing run within a row, and flags each closed span.
// ----------------------------------------------------------------------------
`default_nettype none

module eosf_scan #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [eosf_pkg::PIX_W-1:0] i_pixel,
    input  wire logic                       i_last,
    input  wire logic [eosf_pkg::PIX_W-1:0] i_boundary,
    output logic                            o_hit,
    output eosf_pkg::t_span                 o_span
);

    // The column counter holds MAX_WIDTH itself once it saturates.
    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [1:0] PH_SEEK  = 2'd0;
    localparam logic [1:0] PH_OPEN  = 2'd1;
    localparam logic [1:0] PH_GAP   = 2'd2;
    localparam logic [1:0] PH_CLOSE = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic [COL_W-1:0] r_col,   n_col;
    logic [ROW_W-1:0] r_row,   n_row;
    logic [COL_W-1:0] r_gap,   n_gap;

    logic             w_in_row;
    logic             w_bnd;
    logic             w_clear;
    logic [COL_W-1:0] w_col_prev;

    assign w_in_row   = (r_col < COL_W'(MAX_WIDTH));
    assign w_bnd      = (i_pixel == i_boundary);
    assign w_clear    = (i_pixel == '0);
    assign w_col_prev = r_col - COL_W'(1);

    // Next-state logic for one pixel beat.
    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_gap   = r_gap;
        o_hit   = 1'b0;

        if (w_in_row) begin
            unique case (r_phase)
                PH_SEEK: begin
                    if (w_bnd) n_phase = PH_OPEN;
                end
                PH_OPEN: begin
                    if (w_bnd) begin
                        n_phase = PH_OPEN;
                    end else if (w_clear) begin
                        n_gap   = r_col;
                        n_phase = PH_GAP;
                    end else begin
                        n_phase = PH_SEEK;
                    end
                end
                PH_GAP: begin
                    // Any non-transparent pixel closes the gap.
                    if (w_bnd || !w_clear) begin
                        o_hit   = i_step;
                        n_phase = w_bnd ? PH_CLOSE : PH_SEEK;
                    end
                end
                PH_CLOSE: begin
                    if (!w_bnd) n_phase = PH_SEEK;
                end
                default: n_phase = PH_SEEK;
            endcase
            n_col = r_col + COL_W'(1);
        end

        // End of row: restart the scan and advance the wrapping row count.
        if (i_last) begin
            n_phase = PH_SEEK;
            n_col   = '0;
            n_row   = (r_row == ROW_W'(MAX_HEIGHT - 1)) ? '0 : r_row + ROW_W'(1);
        end
    end

    // Control state is cleared by reset; the gap origin is written before use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_gap <= n_gap;
        end
    end

    // Coordinates are reported in their low bits.
    assign o_span.row   = eosf_pkg::COORD_W'(r_row);
    assign o_span.first = eosf_pkg::COORD_W'(r_gap);
    assign o_span.last  = eosf_pkg::COORD_W'(w_col_prev);

endmodule

`default_nettype wire

### design/even_odd_scanline_span_fill_top.sv
// ----------------------------------------------------------------------------
// even_odd_scanline_span_fill_top
// Finds the transparent spans between boundary runs in a raster pixel
// stream and emits the row and column range of each span to fill.
//
//   Channel   Direction  Handshake                      Beat carries
//   pixel     in         i_pixel_valid / o_pixel_ready  pixel value, last in row
//   span      out        o_span_valid / i_span_ready    row, first and last col
//   config    in         psel / penable / pready        boundary color
//
// One pixel beat is taken every clock unless the pipeline stalls. A pixel is
// captured in the input register, and a span it closes is then registered in
// the output register. Reset is synchronous and starts the scan at row 0,
// column 0. When the span output is held off, the pipeline stalls and
// o_pixel_ready drops once the input register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module even_odd_scanline_span_fill_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Pixel input channel.
    input  wire logic                         i_pixel_valid,
    output logic                              o_pixel_ready,
    input  wire logic [eosf_pkg::PIX_W-1:0]   i_pixel_value,
    input  wire logic                         i_last_in_row,
    // Span output channel.
    output logic                              o_span_valid,
    input  wire logic                         i_span_ready,
    output logic      [eosf_pkg::COORD_W-1:0] o_span_row,
    output logic      [eosf_pkg::COORD_W-1:0] o_span_first,
    output logic      [eosf_pkg::COORD_W-1:0] o_span_last,
    // Configuration port.
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [eosf_pkg::PIX_W-1:0]   pwdata,
    output logic      [eosf_pkg::PIX_W-1:0]   prdata,
    output logic                              pready
);

    logic                       r_in_valid;
    logic [eosf_pkg::PIX_W-1:0] r_pixel;
    logic                       r_last;
    logic                       r_out_valid;
    eosf_pkg::t_span            r_span;

    logic                       w_advance;
    logic                       w_step;
    logic                       w_hit;
    eosf_pkg::t_span            w_span;
    logic [eosf_pkg::PIX_W-1:0] w_boundary;

    // Configuration registers.
    eosf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_boundary (w_boundary)
    );

    // The pipeline moves whenever the output register is free or draining.
    assign w_advance     = !r_out_valid || i_span_ready;
    assign w_step        = r_in_valid && w_advance;
    assign o_pixel_ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_pixel_ready) begin
            r_in_valid <= i_pixel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pixel_ready && i_pixel_valid) begin
            r_pixel <= i_pixel_value;
            r_last  <= i_last_in_row;
        end
    end

    // Scan logic between the input and result registers.
    eosf_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_pixel    (r_pixel),
        .i_last     (r_last),
        .i_boundary (w_boundary),
        .o_hit      (w_hit),
        .o_span     (w_span)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_span <= w_span;
        end
    end

    assign o_span_valid = r_out_valid;
    assign o_span_row   = r_span.row;
    assign o_span_first = r_span.first;
    assign o_span_last  = r_span.last;

endmodule

`default_nettype wire

### bench/eosf_span_checker.sv
// ----------------------------------------------------------------------------
// eosf_span_checker
// Watches the pixel, span and configuration traffic of the even-odd scanline
// span fill block. It keeps its own copy of the scan state, works out the
// fill span that each accepted pixel closes, and compares every span beat
// field by field against the oldest span still owed by the block.
// ----------------------------------------------------------------------------
module eosf_span_checker
    import eosf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Pixel channel, as seen at the block's ports.
    input  logic               i_pixel_valid,
    input  logic               i_pixel_ready,
    input  logic [PIX_W-1:0]   i_pixel_value,
    input  logic               i_last_in_row,
    // Span channel, as seen at the block's ports.
    input  logic               i_span_valid,
    input  logic               i_span_ready,
    input  logic [COORD_W-1:0] i_span_row,
    input  logic [COORD_W-1:0] i_span_first,
    input  logic [COORD_W-1:0] i_span_last,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [PIX_W-1:0]   pwdata,
    input  logic               pready,
    // Status for the stimulus side.
    output int                 o_spans_pending,
    output int                 o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] BOUNDARY_ADDR = 3'(4 * REG_BOUNDARY);

    typedef enum logic [1:0] {
        SEEKING,
        IN_OPEN_RUN,
        IN_GAP,
        SKIPPING_CLOSE
    } t_scan_phase;

    // Scan state of the block as we expect it to be.
    logic [PIX_W-1:0]   boundary  = BOUNDARY_RESET;
    t_scan_phase        phase     = SEEKING;
    int unsigned        col       = 0;
    int unsigned        row       = 0;
    logic [COORD_W-1:0] gap_start = '0;
    t_span              fill_spans[$];
    int                 errors    = 0;

    initial begin
        o_spans_pending = 0;
        o_mismatches    = 0;
    end

    // Advance the scan by one pixel and queue the span it closes, if any.
    task automatic scan_pixel(input logic [PIX_W-1:0] pix, input logic eol);
        logic  hit;
        logic  clear;
        t_span s;
        hit   = (pix == boundary);
        clear = (pix == '0);
        // Columns at or past the row limit are ignored apart from the row end.
        if (col < MAX_WIDTH) begin
            case (phase)
                SEEKING: begin
                    if (hit) phase = IN_OPEN_RUN;
                end
                IN_OPEN_RUN: begin
                    // The boundary test wins, so a zero boundary never opens a gap.
                    if (hit) begin
                        phase = IN_OPEN_RUN;
                    end else if (clear) begin
                        gap_start = COORD_W'(col);
                        phase     = IN_GAP;
                    end else begin
                        phase = SEEKING;
                    end
                end
                IN_GAP: begin
                    if (hit || !clear) begin
                        s.row   = COORD_W'(row);
                        s.first = gap_start;
                        s.last  = COORD_W'(col - 1);
                        fill_spans.push_back(s);
                        phase = hit ? SKIPPING_CLOSE : SEEKING;
                    end
                end
                default: begin
                    if (!hit) phase = SEEKING;
                end
            endcase
            col++;
        end
        // A gap still open here is dropped.
        if (eol) begin
            phase = SEEKING;
            col   = 0;
            row   = (row + 1 >= MAX_HEIGHT) ? 0 : row + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // All observation happens on the rising edge, before the block's own
    // registers move, so every value seen is the one the edge captured.
    always @(posedge i_clk) begin
        t_span want;
        if (!i_rst_n) begin
            boundary  = BOUNDARY_RESET;
            phase     = SEEKING;
            col       = 0;
            row       = 0;
            gap_start = '0;
            fill_spans.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == BOUNDARY_ADDR)
                boundary = pwdata;
            if (i_pixel_valid && i_pixel_ready)
                scan_pixel(i_pixel_value, i_last_in_row);
            if (i_span_valid && i_span_ready) begin
                if (fill_spans.size() == 0) begin
                    $error("unexpected span beat: row %0d, first %0d, last %0d",
                           i_span_row, i_span_first, i_span_last);
                    errors++;
                end else begin
                    want = fill_spans.pop_front();
                    check_field("span_row", want.row, i_span_row);
                    check_field("span_first", want.first, i_span_first);
                    check_field("span_last", want.last, i_span_last);
                end
            end
        end
        o_spans_pending <= fill_spans.size();
        o_mismatches    <= errors;
    end

endmodule

### bench/even_odd_scanline_span_fill_top_tb.sv
// ----------------------------------------------------------------------------
// even_odd_scanline_span_fill_top_tb
// Drives raster rows into the span fill block: a directed set of rows for the
// corner cases, then random rows under several boundary colors and handshake
// pressure. A checker beside the block predicts and compares every span.
// ----------------------------------------------------------------------------
module even_odd_scanline_span_fill_top_tb;
    import eosf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_WIDTH     = 2048;
    localparam int         MAX_HEIGHT    = 2048;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASE_ITEMS   = 220;
    localparam logic [2:0] BOUNDARY_ADDR = 3'(4 * REG_BOUNDARY);

    // Block inputs, all known from time zero.
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_pixel_valid = 1'b0;
    logic [PIX_W-1:0]   i_pixel_value = '0;
    logic               i_last_in_row = 1'b0;
    logic               i_span_ready  = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [2:0]         paddr         = '0;
    logic [PIX_W-1:0]   pwdata        = '0;

    // Block outputs.
    logic               o_pixel_ready;
    logic               o_span_valid;
    logic [COORD_W-1:0] o_span_row;
    logic [COORD_W-1:0] o_span_first;
    logic [COORD_W-1:0] o_span_last;
    logic [PIX_W-1:0]   prdata;
    logic               pready;

    int spans_pending;
    int mismatches;

    // Stimulus knobs and bookkeeping.
    int               tx_idle_pct   = 0;
    int               rx_stall_pct  = 0;
    int               hold_requests = 0;
    int               holds_served  = 0;
    int               hold_left     = 0;
    int               pixels_sent   = 0;
    logic [PIX_W-1:0] cur_boundary  = BOUNDARY_RESET;

    even_odd_scanline_span_fill_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel_value (i_pixel_value),
        .i_last_in_row (i_last_in_row),
        .o_span_valid  (o_span_valid),
        .i_span_ready  (i_span_ready),
        .o_span_row    (o_span_row),
        .o_span_first  (o_span_first),
        .o_span_last   (o_span_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    eosf_span_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) span_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pixel_valid   (i_pixel_valid),
        .i_pixel_ready   (o_pixel_ready),
        .i_pixel_value   (i_pixel_value),
        .i_last_in_row   (i_last_in_row),
        .i_span_valid    (o_span_valid),
        .i_span_ready    (i_span_ready),
        .i_span_row      (o_span_row),
        .i_span_first    (o_span_first),
        .i_span_last     (o_span_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_spans_pending (spans_pending),
        .o_mismatches    (mismatches)
    );

    always #6 i_clk = ~i_clk;

    // Span receiver: random stalls, plus a long hold-off whenever one is asked.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            i_span_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            i_span_ready <= 1'b0;
        end else begin
            i_span_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one pixel beat, sometimes after a random idle gap, and wait until it is taken.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic eol);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel_value <= pix;
        i_last_in_row <= eol;
        do @(posedge i_clk); while (!o_pixel_ready);
        pixels_sent++;
    endtask

    // One row built from boundary runs, transparent runs and other colors,
    // with a share of rows that are plain noise.
    task automatic send_row(input int len);
        int               kind;
        int               run;
        bit               noisy;
        logic [PIX_W-1:0] pix;
        run   = 0;
        kind  = 0;
        noisy = ($urandom_range(99) < 15);
        for (int c = 0; c < len; c++) begin
            if (noisy) begin
                pix = $urandom_range(1) ? PIX_W'($urandom()) : '0;
            end else begin
                if (run == 0) begin
                    kind = $urandom_range(99);
                    run  = (kind < 70) ? $urandom_range(1, 4) : 1;
                end
                run--;
                if (kind < 35)
                    pix = cur_boundary;
                else if (kind < 70)
                    pix = '0;
                else if (kind < 88)
                    pix = PIX_W'($urandom());
                else
                    pix = cur_boundary ^ (PIX_W'(1) << $urandom_range(PIX_W - 1));
            end
            send_pixel(pix, c == len - 1);
        end
    endtask

    // Stop offering pixels and wait until every span owed has been taken,
    // then let the pipeline settle.
    task automatic drain_spans();
        i_pixel_valid <= 1'b0;
        do @(posedge i_clk); while (spans_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the boundary color while the block is idle.
    task automatic write_boundary(input logic [PIX_W-1:0] color);
        drain_spans();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BOUNDARY_ADDR;
        pwdata  <= color;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_boundary = color;
    endtask

    initial begin
        logic [PIX_W-1:0] bnd;
        logic [PIX_W-1:0] colors[8];
        int               target;

        colors = '{BOUNDARY_RESET, 32'hFFFF_FFFF, 32'h0000_0000, PIX_W'($urandom()),
                   32'h0000_0001, 32'h8000_0000, PIX_W'($urandom()), BOUNDARY_RESET};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset boundary color.
        bnd = BOUNDARY_RESET;
        // Span closed by a boundary run; that run is skipped; a gap left
        // open at the row end is dropped.
        send_pixel(bnd, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(bnd, 1'b0);
        send_pixel(bnd, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(bnd, 1'b0);
        send_pixel('0, 1'b1);
        // Empty gap, then a one-column span closed by another color at the row end.
        send_pixel(bnd, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(bnd, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(32'hDEAD_BEEF, 1'b1);
        // Single-pixel row.
        send_pixel(bnd, 1'b1);
        // Span closed by a boundary pixel that also ends the row.
        send_pixel('0, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(bnd, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(bnd, 1'b1);

        // Random rows under several colors and handshake patterns.
        for (int ph = 0; ph < 8; ph++) begin
            write_boundary(colors[ph]);
            case (ph % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 74;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 74;
                end
                default: begin
                    tx_idle_pct = 33;
                    rx_stall_pct <= 33;
                end
            endcase
            // Hold the span output off while pixels keep coming, so the block
            // backs up and stalls its input.
            if (ph == 4)
                hold_requests <= hold_requests + 1;
            target = pixels_sent + PHASE_ITEMS;
            while (pixels_sent < target) begin
                if ($urandom_range(99) < 5)
                    send_row($urandom_range(40, 100));
                else
                    send_row($urandom_range(3, 24));
            end
        end

        drain_spans();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
design/eosf_pkg.sv
design/eosf_cfg.sv
design/eosf_scan.sv
design/even_odd_scanline_span_fill_top.sv
bench/eosf_span_checker.sv
bench/even_odd_scanline_span_fill_top_tb.sv
